FILE: rtl/grpc_pkg.sv
// Shared types and gear table constants for the gear ratio plausibility check.
package grpc_pkg;

    localparam int TABLE_LEN = 10;
    localparam int IDX_W     = 4;
    localparam int GEAR_W    = 4;
    localparam int SPEED_W   = 16;
    localparam int PROD_W    = 32;

    localparam logic [GEAR_W-1:0] GEAR_NUM [TABLE_LEN] = '{
        4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12
    };

    localparam logic [15:0] GEAR_Q88 [TABLE_LEN] = '{
        16'd45888, 16'd27825, 16'd22277, 16'd17203, 16'd13381,
        16'd10591, 16'd8113,  16'd6354,  16'd4959,  16'd3901
    };

    typedef struct packed {
        logic [PROD_W-1:0] hi;
        logic [PROD_W-1:0] lo;
        logic [IDX_W-1:0]  idx;
        logic              en;
    } cand_t;

    typedef struct packed {
        logic [GEAR_W-1:0] cur;
        logic              check;
        logic              eng_pos;
    } side_t;

endpackage

FILE: rtl/gear_ratio_plausibility_check.sv
// Gear ratio plausibility check: a pipeline that flags ratios that contradict the engaged gear.
// The per-gear ratio products are registered, then ordered into pairs and registered again;
// four tournament levels follow, each registering cross products and then the selection,
// and one output register follows.
// Throughput is one word per cycle; each stage holds while the stage after it is full and stalled.
// Reset clears all stage valid bits and sets the wheel speed floor to 16 (1.0 in Q12.4).
module gear_ratio_plausibility_check
    import grpc_pkg::*;
#(
    parameter int NUM_GEARS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // wheel speed floor
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // engine, wheel, current gear, selected gear, slip
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // anomaly_hit
);

    localparam int USED_LEN = (NUM_GEARS < TABLE_LEN) ? NUM_GEARS : TABLE_LEN;
    localparam int NSTG     = 11;

    logic [SPEED_W-1:0] wheel_floor_reg;
    logic [NSTG-1:0]    v_reg;
    logic [NSTG-1:0]    en;

    logic [SPEED_W-1:0] eng;
    logic [SPEED_W-1:0] whl;
    logic [GEAR_W-1:0]  cur;
    logic [GEAR_W-1:0]  sel;
    logic [SPEED_W-1:0] slip;
    logic               known;
    side_t              side_s1_next;

    logic [PROD_W-1:0]  a_reg [TABLE_LEN];
    logic [PROD_W-1:0]  b_reg;
    side_t              side_s1_reg;
    cand_t              cand_l0 [TABLE_LEN];
    side_t              side_l0;
    cand_t              cand_l1 [5];
    side_t              side_l1;
    cand_t              cand_l2 [3];
    side_t              side_l2;
    cand_t              cand_l3 [2];
    side_t              side_l3;
    cand_t              cand_l4 [1];
    side_t              side_l4;
    logic               hit_next;
    logic               hit_reg;

    assign eng  = s_tdata[15:0];
    assign whl  = s_tdata[31:16];
    assign cur  = s_tdata[35:32];
    assign sel  = s_tdata[39:36];
    assign slip = s_tdata[55:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_floor_reg <= 16'd16;
        end else if (cfg_wr_en) begin
            wheel_floor_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb begin
        known = 1'b0;
        for (int i = 0; i < USED_LEN; i++) begin
            if (GEAR_NUM[i] == cur) begin
                known = 1'b1;
            end
        end
        side_s1_next.cur     = cur;
        side_s1_next.check   = (whl >= wheel_floor_reg) && known && (cur == sel)
                               && (slip == '0);
        side_s1_next.eng_pos = (eng != '0) && !eng[SPEED_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < TABLE_LEN; i++) begin
                a_reg[i] <= PROD_W'(GEAR_Q88[i]) * PROD_W'(whl);
            end
            b_reg       <= PROD_W'({eng[SPEED_W-2:0], 8'h00});
            side_s1_reg <= side_s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < TABLE_LEN; i++) begin
                cand_l0[i].hi  <= (a_reg[i] > b_reg) ? a_reg[i] : b_reg;
                cand_l0[i].lo  <= (a_reg[i] > b_reg) ? b_reg : a_reg[i];
                cand_l0[i].idx <= IDX_W'(i);
                cand_l0[i].en  <= (i < USED_LEN);
            end
            side_l0 <= side_s1_reg;
        end
    end

    grpc_level #(.N_IN(10)) u_level0 (
        .aclk     (aclk),
        .en_mul   (en[2]),
        .en_cmp   (en[3]),
        .cand_in  (cand_l0),
        .side_in  (side_l0),
        .cand_out (cand_l1),
        .side_out (side_l1)
    );

    grpc_level #(.N_IN(5)) u_level1 (
        .aclk     (aclk),
        .en_mul   (en[4]),
        .en_cmp   (en[5]),
        .cand_in  (cand_l1),
        .side_in  (side_l1),
        .cand_out (cand_l2),
        .side_out (side_l2)
    );

    grpc_level #(.N_IN(3)) u_level2 (
        .aclk     (aclk),
        .en_mul   (en[6]),
        .en_cmp   (en[7]),
        .cand_in  (cand_l2),
        .side_in  (side_l2),
        .cand_out (cand_l3),
        .side_out (side_l3)
    );

    grpc_level #(.N_IN(2)) u_level3 (
        .aclk     (aclk),
        .en_mul   (en[8]),
        .en_cmp   (en[9]),
        .cand_in  (cand_l3),
        .side_in  (side_l3),
        .cand_out (cand_l4),
        .side_out (side_l4)
    );

    assign hit_next = side_l4.check
                      && (!side_l4.eng_pos || (GEAR_NUM[cand_l4[0].idx] != side_l4.cur));

    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            hit_reg <= hit_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTG-1];
    assign m_tdata  = {7'b0, hit_reg};

endmodule

FILE: rtl/grpc_level.sv
// One two-stage level of the closest-ratio tournament: cross products, then selection.
module grpc_level
    import grpc_pkg::*;
#(
    parameter int N_IN = 2
) (
    input  logic  aclk,
    input  logic  en_mul,
    input  logic  en_cmp,
    input  cand_t cand_in [N_IN],
    input  side_t side_in,
    output cand_t cand_out [(N_IN + 1) / 2],
    output side_t side_out
);

    localparam int N_PAIR = N_IN / 2;
    localparam int N_OUT  = (N_IN + 1) / 2;

    cand_t                 cand_m_reg [N_IN];
    side_t                 side_m_reg;
    logic [2*PROD_W-1:0]   prod_l_reg [N_PAIR];
    logic [2*PROD_W-1:0]   prod_r_reg [N_PAIR];
    cand_t                 cand_c_next [N_OUT];
    cand_t                 cand_c_reg [N_OUT];
    side_t                 side_c_reg;

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            cand_m_reg <= cand_in;
            side_m_reg <= side_in;
            for (int k = 0; k < N_PAIR; k++) begin
                prod_l_reg[k] <= (2*PROD_W)'(cand_in[2*k].hi) * (2*PROD_W)'(cand_in[2*k+1].lo);
                prod_r_reg[k] <= (2*PROD_W)'(cand_in[2*k+1].hi) * (2*PROD_W)'(cand_in[2*k].lo);
            end
        end
    end

    // The right entry wins a pair only when it is strictly closer, so ties keep the earlier one.
    always_comb begin
        for (int k = 0; k < N_PAIR; k++) begin
            if (cand_m_reg[2*k+1].en && (prod_r_reg[k] < prod_l_reg[k])) begin
                cand_c_next[k] = cand_m_reg[2*k+1];
            end else begin
                cand_c_next[k] = cand_m_reg[2*k];
            end
        end
        if (N_OUT > N_PAIR) begin
            cand_c_next[N_OUT-1] = cand_m_reg[N_IN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_cmp) begin
            cand_c_reg <= cand_c_next;
            side_c_reg <= side_m_reg;
        end
    end

    assign cand_out = cand_c_reg;
    assign side_out = side_c_reg;

endmodule
